// ===== sv/q1418_pkg.sv =====
// ----------------------------------------------------------------------------
// q1418_pkg: shared types and constants of the Q14.18 arithmetic unit
// Word and fraction widths, command codes, item structs and helpers.
// ----------------------------------------------------------------------------
package q1418_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned FRAC_BITS = 18;
  localparam int unsigned CMD_BITS  = 3;

  localparam logic [WORD_BITS-1:0] FRAC_MASK = {{(WORD_BITS-FRAC_BITS){1'b0}},
                                                {FRAC_BITS{1'b1}}};
  localparam logic [WORD_BITS-1:0] ONE_UNIT  = WORD_BITS'(1) << FRAC_BITS;
  localparam logic [WORD_BITS-1:0] HALF_UNIT = WORD_BITS'(1) << (FRAC_BITS - 1);

  // Command codes; code 7 is unused and yields a zero result
  typedef enum logic [CMD_BITS-1:0] {
    CMD_MUL   = 3'd0,
    CMD_DIV   = 3'd1,
    CMD_ABS   = 3'd2,
    CMD_FRAC  = 3'd3,
    CMD_FLOOR = 3'd4,
    CMD_CEIL  = 3'd5,
    CMD_ROUND = 3'd6
  } cmd_e;

  // Input item
  typedef struct packed {
    logic [CMD_BITS-1:0]         cmd;
    logic signed [WORD_BITS-1:0] a;
    logic signed [WORD_BITS-1:0] b;
  } req_t;

  // Result item
  typedef struct packed {
    logic signed [WORD_BITS-1:0] result;
    logic                        div_by_zero;
  } rsp_t;

  // Classified item as queued between front and back
  typedef struct packed {
    logic [CMD_BITS-1:0]  cmd;
    logic [WORD_BITS-1:0] a;
    logic [WORD_BITS-1:0] b;
    logic                 use_div;  // divide with nonzero divisor
    logic                 dz;       // divide by zero
  } task_t;

  // Two's complement magnitude; most negative value maps to itself
  function automatic logic [WORD_BITS-1:0] magnitude(input logic [WORD_BITS-1:0] v);
    magnitude = v[WORD_BITS-1] ? (WORD_BITS'(0) - v) : v;
  endfunction

endpackage

// ===== sv/q1418_front.sv =====
// ----------------------------------------------------------------------------
// q1418_front: item intake and classification
// Accepts items, tags divides and zero divisors, and queues them for the back.
// ----------------------------------------------------------------------------
module q1418_front #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  q1418_pkg::req_t     req_i,
  output logic                head_valid_o,
  output q1418_pkg::task_t    head_o,
  input  logic                pop_i
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  q1418_pkg::task_t mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push;
  q1418_pkg::task_t cls;

  // Classify the incoming item
  always_comb begin
    cls.cmd     = req_i.cmd;
    cls.a       = req_i.a;
    cls.b       = req_i.b;
    cls.use_div = (req_i.cmd == q1418_pkg::CMD_DIV) && (req_i.b != '0);
    cls.dz      = (req_i.cmd == q1418_pkg::CMD_DIV) && (req_i.b == '0);
  end

  assign busy_o       = (count_q == CntW'(QUEUE_DEPTH));
  assign push         = start_i && !busy_o;
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CntW'(push) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("pop from empty queue");

endmodule

// ===== sv/q1418_div.sv =====
// ----------------------------------------------------------------------------
// q1418_div: iterative fixed-point divider
// Restoring division of |a| << FRAC_BITS by |b|, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module q1418_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [q1418_pkg::WORD_BITS-1:0]     a_i,
  input  logic [q1418_pkg::WORD_BITS-1:0]     b_i,
  output logic                                busy_o,
  output logic                                done_o,
  output logic [q1418_pkg::WORD_BITS-1:0]     quot_o
);

  localparam int unsigned W    = q1418_pkg::WORD_BITS;
  localparam int unsigned N    = q1418_pkg::WORD_BITS + q1418_pkg::FRAC_BITS;
  localparam int unsigned CntW = $clog2(N + 1);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [N-1:0]    qr_q, qr_d;    // dividend bits shift out, quotient bits in
  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    den_q;
  logic            neg_q;
  logic [W:0]      rem_w;
  logic            ge;

  // One restoring step
  always_comb begin
    rem_w = {rem_q, qr_q[N-1]};
    ge    = (rem_w >= {1'b0, den_q});
    rem_d = ge ? W'(rem_w - {1'b0, den_q}) : rem_w[W-1:0];
    qr_d  = {qr_q[N-2:0], ge};
  end

  assign busy_o = busy_q;
  assign done_o = busy_q && (cnt_q == CntW'(N));
  assign quot_o = neg_q ? (W'(0) - qr_q[W-1:0]) : qr_q[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      qr_q  <= {q1418_pkg::magnitude(a_i), {q1418_pkg::FRAC_BITS{1'b0}}};
      rem_q <= '0;
      den_q <= q1418_pkg::magnitude(b_i);
      neg_q <= a_i[W-1] ^ b_i[W-1];
    end else if (busy_q && !done_o) begin
      qr_q  <= qr_d;
      rem_q <= rem_d;
    end
  end

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_q)
    else $error("divider stayed busy after done");

endmodule

// ===== sv/q1418_back.sv =====
// ----------------------------------------------------------------------------
// q1418_back: execution unit
// Two-stage pipe for multiply and single-word ops, with a side divider.
// ----------------------------------------------------------------------------
module q1418_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  q1418_pkg::task_t  head_i,
  output logic              pop_o,
  output logic              done_o,
  output q1418_pkg::rsp_t   rsp_o
);

  localparam int unsigned W = q1418_pkg::WORD_BITS;
  localparam int unsigned F = q1418_pkg::FRAC_BITS;

  logic                    div_busy, div_done, div_start;
  logic [W-1:0]            div_quot;
  logic                    s1_valid_q, s1_mul_q, s1_dz_q;
  logic [W-1:0]            s1_res_q;
  logic signed [2*W-1:0]   s1_prod_q;
  logic [W-1:0]            mag, flr, rnd, res;
  logic                    done_q;
  q1418_pkg::rsp_t         rsp_q;

  assign pop_o     = head_valid_i && !div_busy;
  assign div_start = pop_o && head_i.use_div;

  q1418_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .a_i    (head_i.a),
    .b_i    (head_i.b),
    .busy_o (div_busy),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Single-word operations
  always_comb begin
    mag = q1418_pkg::magnitude(head_i.a);
    flr = head_i.a & ~q1418_pkg::FRAC_MASK;
    rnd = (mag + q1418_pkg::HALF_UNIT) & ~q1418_pkg::FRAC_MASK;
    if (head_i.a[W-1]) begin
      rnd = W'(0) - rnd;
    end
    unique case (q1418_pkg::cmd_e'(head_i.cmd))
      q1418_pkg::CMD_ABS:   res = mag;
      q1418_pkg::CMD_FRAC:  res = mag & q1418_pkg::FRAC_MASK;
      q1418_pkg::CMD_FLOOR: res = flr;
      q1418_pkg::CMD_CEIL:  res = ((head_i.a & q1418_pkg::FRAC_MASK) != '0)
                                  ? flr + q1418_pkg::ONE_UNIT : head_i.a;
      q1418_pkg::CMD_ROUND: res = rnd;
      default:              res = '0;
    endcase
  end

  // Stage 1: product and simple result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= pop_o && !head_i.use_div;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_prod_q <= $signed(head_i.a) * $signed(head_i.b);
    s1_mul_q  <= (head_i.cmd == q1418_pkg::CMD_MUL);
    s1_dz_q   <= head_i.dz;
    s1_res_q  <= res;
  end

  // Stage 2: result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s1_valid_q || div_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      rsp_q.result      <= div_quot;
      rsp_q.div_by_zero <= 1'b0;
    end else begin
      rsp_q.result      <= s1_mul_q ? s1_prod_q[F+W-1:F] : s1_res_q;
      rsp_q.div_by_zero <= s1_dz_q;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_no_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_valid_q && div_done))
    else $error("pipe result and divider result collide");
  a_no_pop_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> !pop_o)
    else $error("queue popped while divider runs");

endmodule

// ===== sv/fixed_point_q14_18_alu_core.sv =====
// ----------------------------------------------------------------------------
// fixed_point_q14_18_alu_core: Q14.18 fixed-point arithmetic unit
// Multiply, divide, abs, frac, floor, ceil and round on signed 32-bit words.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low; busy_o rises only
// when the input queue of QUEUE_DEPTH items is full. Multiply and the
// single-word operations take one item per cycle while no divide is running,
// and pass through the queue, stage 1 and the result register. A divide
// with a nonzero divisor runs on a bit-serial divider while later items wait
// in the queue. Results come out in order, each for one cycle with done_o
// high, and must be taken then.
module fixed_point_q14_18_alu_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  q1418_pkg::req_t  req_i,
  output logic             done_o,
  output q1418_pkg::rsp_t  rsp_o
);

  logic             head_valid, pop;
  q1418_pkg::task_t head;

  q1418_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .head_valid_o(head_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  q1418_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

endmodule

// ===== tb/fixed_point_q14_18_alu_checker.sv =====
// ----------------------------------------------------------------------------
// fixed_point_q14_18_alu_checker: result predictor and scoreboard
// Watches the item and result channels of the Q14.18 unit, computes the
// expected result of every accepted item and compares results in order.
// ----------------------------------------------------------------------------
module fixed_point_q14_18_alu_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  q1418_pkg::req_t    req_i,
  input  logic               done_i,
  input  q1418_pkg::rsp_t    rsp_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 results_seen_o
);

  q1418_pkg::rsp_t expected_results[$];

  // Q14.18 arithmetic done in wide signed vectors
  function automatic q1418_pkg::rsp_t compute_q1418(q1418_pkg::req_t r);
    q1418_pkg::rsp_t o;
    logic signed [63:0]  prod;
    logic signed [127:0] num;
    logic signed [127:0] quo;
    logic [31:0] mag;
    o.result = '0;
    o.div_by_zero = 1'b0;
    mag = r.a[31] ? (32'd0 - r.a) : r.a;
    case (r.cmd)
      q1418_pkg::CMD_MUL: begin
        prod = 64'(r.a) * 64'(r.b);
        o.result = 32'(prod >>> q1418_pkg::FRAC_BITS);
      end
      q1418_pkg::CMD_DIV: begin
        if (r.b == 0) begin
          o.div_by_zero = 1'b1;
        end else begin
          // signed division truncates toward zero
          num = 128'(r.a) <<< q1418_pkg::FRAC_BITS;
          quo = num / 128'(r.b);
          o.result = 32'(quo);
        end
      end
      q1418_pkg::CMD_ABS:   o.result = mag;
      q1418_pkg::CMD_FRAC:  o.result = mag & q1418_pkg::FRAC_MASK;
      q1418_pkg::CMD_FLOOR: o.result = r.a & ~q1418_pkg::FRAC_MASK;
      q1418_pkg::CMD_CEIL: begin
        if ((r.a & q1418_pkg::FRAC_MASK) == 0) o.result = r.a;
        else o.result = (r.a & ~q1418_pkg::FRAC_MASK) + q1418_pkg::ONE_UNIT;
      end
      q1418_pkg::CMD_ROUND: begin
        o.result = (mag + q1418_pkg::HALF_UNIT) & ~q1418_pkg::FRAC_MASK;
        if (r.a[31]) o.result = 32'd0 - o.result;
      end
      default: o.result = '0;
    endcase
    return o;
  endfunction

  // predict on accept, compare on strobe
  always @(posedge clk_i or negedge rst_ni) begin
    q1418_pkg::rsp_t exp_r;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      fail_count_o   <= 0;
      results_seen_o <= 0;
      pending_o      <= 0;
      expected_results.delete();
    end else begin
      if (done_i) begin
        results_seen_o <= results_seen_o + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h/%b", $time, rsp_i.result, rsp_i.div_by_zero);
          errs++;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.result !== rsp_i.result) begin
            $display("%0t: result mismatch expected %h actual %h", $time,
                     exp_r.result, rsp_i.result);
            errs++;
          end
          if (exp_r.div_by_zero !== rsp_i.div_by_zero) begin
            $display("%0t: div_by_zero mismatch expected %b actual %b", $time,
                     exp_r.div_by_zero, rsp_i.div_by_zero);
            errs++;
          end
        end
      end
      if (start_i && !busy_i) expected_results.push_back(compute_q1418(req_i));
      fail_count_o <= fail_count_o + errs;
      pending_o    <= expected_results.size();
    end
  end

endmodule

// ===== tb/fixed_point_q14_18_alu_core_test.sv =====
// ----------------------------------------------------------------------------
// fixed_point_q14_18_alu_core_test: top of the Q14.18 unit testbench
// Drives directed corner items, then random items with random gaps outside a
// middle stretch, and reports the verdict from mismatch and pending counts.
// ----------------------------------------------------------------------------
module fixed_point_q14_18_alu_core_test;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 730;

  logic            clk_i;
  logic            rst_ni;
  logic            start_i;
  logic            busy_o;
  q1418_pkg::req_t req_i;
  logic            done_o;
  q1418_pkg::rsp_t rsp_o;
  int              fail_count;
  int              pending;
  int              results_seen;
  int              idle_cycles;
  int              items_sent;
  int              div_items;

  fixed_point_q14_18_alu_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .req_i(req_i), .done_o(done_o), .rsp_o(rsp_o)
  );

  fixed_point_q14_18_alu_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_i(busy_o),
    .req_i(req_i), .done_i(done_o), .rsp_i(rsp_o), .fail_count_o(fail_count),
    .pending_o(pending), .results_seen_o(results_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog: cycles with no item and no result accepted
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // present one item and hold it until taken; gaps at random when allowed
  task automatic send_item(input logic [2:0] cmd, input logic [31:0] a,
                           input logic [31:0] b, input bit allow_gaps);
    while (allow_gaps && $urandom_range(99) < 14) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i   <= 1'b1;
    req_i.cmd <= cmd;
    req_i.a   <= a;
    req_i.b   <= b;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
    if (cmd == q1418_pkg::CMD_DIV) div_items++;
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(5))
      0: return 32'h8000_0000 + $urandom_range(3);
      1: return 32'h7FFF_FFFF - $urandom_range(3);
      2: return {$urandom_range(1) ? 14'h3FFF : 14'h0, 18'($urandom)};
      3: return {14'($urandom), $urandom_range(1) ? 18'h20000 : 18'h0};
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [2:0]  cmd;
    logic [31:0] a;
    logic [31:0] b;
    bit          gaps;
    rst_ni = 1'b0;
    start_i = 1'b0;
    req_i = '0;
    items_sent = 0;
    div_items = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed corners: extremes, every command, special cases
    send_item(q1418_pkg::CMD_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_item(q1418_pkg::CMD_MUL, 32'h8000_0000, 32'h8000_0000, 0);
    send_item(q1418_pkg::CMD_MUL, 32'hFFFF_FFFF, 32'h0004_0000, 0);
    send_item(q1418_pkg::CMD_DIV, 32'h0004_0000, 32'h0000_0000, 0);
    send_item(q1418_pkg::CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 0);
    send_item(q1418_pkg::CMD_DIV, 32'h7FFF_FFFF, 32'h0000_0001, 0);
    send_item(q1418_pkg::CMD_DIV, 32'hFFF8_0000, 32'h0003_0000, 0);
    send_item(q1418_pkg::CMD_ABS, 32'h8000_0000, 32'h0, 0);
    send_item(q1418_pkg::CMD_ABS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_item(q1418_pkg::CMD_FRAC, 32'hFFFE_8000, 32'h0, 0);
    send_item(q1418_pkg::CMD_FLOOR, 32'hFFFE_8000, 32'h0, 0);
    send_item(q1418_pkg::CMD_FLOOR, 32'h8000_0000, 32'h0, 0);
    send_item(q1418_pkg::CMD_CEIL, 32'hFFFE_8000, 32'h0, 0);
    send_item(q1418_pkg::CMD_CEIL, 32'h7FFF_FFFF, 32'h0, 0);
    send_item(q1418_pkg::CMD_CEIL, 32'h0004_0000, 32'h0, 0);
    send_item(q1418_pkg::CMD_ROUND, 32'h0002_0000, 32'h0, 0);
    send_item(q1418_pkg::CMD_ROUND, 32'hFFFE_0000, 32'h0, 0);
    send_item(q1418_pkg::CMD_ROUND, 32'h7FFF_FFFF, 32'h0, 0);
    send_item(q1418_pkg::CMD_ROUND, 32'h8000_0000, 32'h0, 0);
    send_item(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    start_i <= 1'b0;

    // hold off until the unit has drained
    while (pending != 0) @(negedge clk_i);

    // random items; the middle stretch runs back to back
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      gaps = (i < 250 || i >= 450);
      cmd = (i % 8 == 7) ? 3'($urandom_range(7)) : 3'($urandom_range(6));
      // keep slow divides to a minority of items
      if (cmd == q1418_pkg::CMD_DIV && $urandom_range(2) != 0) cmd = q1418_pkg::CMD_MUL;
      a = pick_operand();
      b = ($urandom_range(19) == 0) ? 32'h0 : pick_operand();
      send_item(cmd, a, b, gaps);
    end
    start_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    $display("covered %0d items (%0d divides) and %0d results, all commands and corners",
             items_sent, div_items, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
